>>> rtl/vbe_pkg.sv
// Package with the opcodes, controller states and control structs of the varint encoder.
`timescale 1ns / 1ps

package vbe_pkg;

   // Input opcodes.
   localparam logic [2:0] OP_UVAR  = 3'd0;
   localparam logic [2:0] OP_SVAR  = 3'd1;
   localparam logic [2:0] OP_BIT   = 3'd2;
   localparam logic [2:0] OP_BYTE  = 3'd3;
   localparam logic [2:0] OP_FLUSH = 3'd4;

   // Group sizes of the varint code.
   localparam int GROUP_BITS       = 7;
   localparam int FIRST_SIGNED_BITS = 6;
   localparam logic [3:0] FULL_BYTE_BITS = 4'd8;

   // Controller states.
   typedef enum logic [0:0] {
      ST_IDLE,
      ST_RUN
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
   } vbe_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_free;
      logic step_done;
   } vbe_sts_type;

endpackage

>>> rtl/varint_bitstream_encoder.sv
// Top level of the varint bit-stream encoder: controller plus datapath.
`timescale 1ns / 1ps

// The encoder appends varints, single bits and raw bytes to a byte stream,
// least significant bit first, and sends each completed byte with its valid
// bit count and a last flag on the final byte of the item. An item is accepted
// in the idle state and then takes one step per cycle while the output register
// is free: a varint takes one step per 7-bit group (up to ten), every other
// opcode one step. The single output register moves one byte per cycle while
// the receiver is ready. A new item is accepted in the idle state that follows
// the previous item's last step, even while its final byte still waits in the
// output register.
module varint_bitstream_encoder
   import vbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [3:0]  rsp_valid_bits,
   output logic        rsp_last
);

   vbe_cmd_type cmd;
   vbe_sts_type sts;

   vbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   vbe_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_opcode     (req_opcode),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_valid_bits (rsp_valid_bits),
      .rsp_last       (rsp_last)
   );

endmodule

>>> rtl/vbe_ctrl.sv
// Controller state machine that sequences one input item through the datapath.
`timescale 1ns / 1ps

module vbe_ctrl
   import vbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  vbe_sts_type sts,
   output vbe_cmd_type cmd
);

   ctl_state_type state_ff;
   ctl_state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: an item is loaded in idle, then stepped until its final step.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RUN;
            end
         end
         ST_RUN: begin
            if (sts.out_free && sts.step_done) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs: ready and load in idle; in run a step runs whenever the output register can take a byte.
   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_RUN: begin
            cmd.step = sts.out_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

>>> rtl/vbe_datapath.sv
// Datapath with the operand register, the partial byte and the output register.
`timescale 1ns / 1ps

module vbe_datapath
   import vbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  vbe_cmd_type cmd,
   output vbe_sts_type sts,
   input  logic [2:0]  req_opcode,
   input  logic [63:0] req_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_out_byte,
   output logic [3:0]  rsp_valid_bits,
   output logic        rsp_last
);

   logic [2:0]  op_ff;
   logic [63:0] val_ff,     val_in;
   logic        sign_ff;
   logic        first_ff;
   logic [7:0]  partial_ff, partial_in;
   logic [2:0]  fill_ff,    fill_in;
   logic        rsp_valid_ff;
   logic [7:0]  rsp_byte_ff;
   logic [3:0]  rsp_bits_ff;
   logic        rsp_last_ff;

   logic        emit;
   logic        done;
   logic [7:0]  emit_byte;
   logic [3:0]  emit_bits;
   logic [7:0]  chunk;
   logic        cont;
   logic [15:0] merged;
   logic [7:0]  bit_merged;
   logic        out_free;

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign sts.out_free  = out_free;
   assign sts.step_done = done;

   // Eight-bit chunk merged at the current fill offset.
   assign merged     = ({8'd0, chunk} << fill_ff) | {8'd0, partial_ff};
   assign bit_merged = partial_ff | ({7'd0, val_ff[0]} << fill_ff);

   // One step of the current item: at most one byte leaves per step.
   always_comb begin
      val_in     = val_ff;
      partial_in = partial_ff;
      fill_in    = fill_ff;
      emit       = 1'b0;
      done       = 1'b1;
      emit_byte  = merged[7:0];
      emit_bits  = FULL_BYTE_BITS;
      chunk      = val_ff[7:0];
      cont       = 1'b0;
      case (op_ff)
         OP_UVAR, OP_SVAR: begin
            if (op_ff == OP_SVAR && first_ff) begin
               // Sign bit, six magnitude bits and the continuation bit.
               val_in = val_ff >> FIRST_SIGNED_BITS;
               cont   = |val_in;
               chunk  = {cont, val_ff[FIRST_SIGNED_BITS-1:0], sign_ff};
            end else begin
               val_in = val_ff >> GROUP_BITS;
               cont   = |val_in;
               chunk  = {cont, val_ff[GROUP_BITS-1:0]};
            end
            emit       = 1'b1;
            done       = !cont;
            emit_byte  = merged[7:0];
            partial_in = merged[15:8];
         end
         OP_BYTE: begin
            chunk      = val_ff[7:0];
            emit       = 1'b1;
            emit_byte  = merged[7:0];
            partial_in = merged[15:8];
         end
         OP_BIT: begin
            emit_byte = bit_merged;
            if (fill_ff == 3'd7) begin
               emit       = 1'b1;
               partial_in = 8'd0;
               fill_in    = 3'd0;
            end else begin
               partial_in = bit_merged;
               fill_in    = fill_ff + 3'd1;
            end
         end
         OP_FLUSH: begin
            emit       = (fill_ff != 3'd0);
            emit_byte  = partial_ff;
            emit_bits  = {1'b0, fill_ff};
            partial_in = 8'd0;
            fill_in    = 3'd0;
         end
         default: begin
            emit = 1'b0;
         end
      endcase
   end

   // Operand registers, loaded on a transfer and shifted on each step.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_opcode;
         first_ff <= 1'b1;
         if (req_opcode == OP_SVAR && req_value[63]) begin
            val_ff  <= (~req_value) + 64'd1;
            sign_ff <= 1'b0;
         end else begin
            val_ff  <= req_value;
            sign_ff <= 1'b1;
         end
      end else if (cmd.step) begin
         val_ff   <= val_in;
         first_ff <= 1'b0;
      end
   end

   // Partial byte and its bit count.
   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= 8'd0;
         fill_ff    <= 3'd0;
      end else if (cmd.step) begin
         partial_ff <= partial_in;
         fill_ff    <= fill_in;
      end
   end

   // Output register; a new byte is only written when the old one is gone.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.step && emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.step && emit) begin
         rsp_byte_ff <= emit_byte;
         rsp_bits_ff <= emit_bits;
         rsp_last_ff <= done;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_valid_bits = rsp_bits_ff;
   assign rsp_last       = rsp_last_ff;

endmodule

>>> rtl/vbe_checker.sv
// Port checker for the varint encoder and its bind to the top level.
`timescale 1ns / 1ps

module vbe_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [7:0]  rsp_out_byte,
   input logic [3:0]  rsp_valid_bits,
   input logic        rsp_last
);

   // A stalled result transfer stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   // A stalled result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_out_byte) && $stable(rsp_valid_bits) && $stable(rsp_last))
      else $error("result payload changed while stalled");

   // Bit counts stay between one and eight.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_valid_bits != 4'd0 && rsp_valid_bits <= 4'd8)
      else $error("bad valid bit count");

   // A short byte only comes from a flush, which is always the item's last byte.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_bits != 4'd8 |-> rsp_last)
      else $error("partial byte not marked last");

   // Nothing is offered in the first cycle after reset is released.
   assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result offered after reset");

endmodule

bind varint_bitstream_encoder vbe_checker u_vbe_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_out_byte   (rsp_out_byte),
   .rsp_valid_bits (rsp_valid_bits),
   .rsp_last       (rsp_last)
);

>>> bench/varint_bitstream_encoder_tb.sv
// Self-checking testbench for the varint bit-stream encoder with a bit-level stream predictor.
`timescale 1ns / 1ps

module varint_bitstream_encoder_tb;
   import vbe_pkg::*;

   localparam int IDLE_LIMIT   = 1000;
   localparam int HOLD_CYCLES  = 200;
   localparam int TAIL_CYCLES  = 30;
   localparam int RESET_CYCLES = 11;
   localparam int MAX_WAIT     = 15;
   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
   localparam logic [63:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;
   localparam logic [63:0] MOST_POSITIVE = 64'h7FFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [7:0] data;
      logic [3:0] nbits;
      logic       last;
   } coded_byte_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_opcode = OP_UVAR;
   logic [63:0] req_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [3:0]  rsp_valid_bits;
   logic        rsp_last;

   // Predicted stream: bytes still owed by the block, and those of the current item.
   coded_byte_type expected_bytes[$];
   coded_byte_type item_bytes[$];
   logic [7:0]  pend_byte = '0;
   int          pend_fill = 0;

   int error_count = 0;
   int idle_cycles = 0;
   int hold_len = 0;
   bit tx_gapless = 1'b0;
   bit rx_gapless = 1'b0;

   varint_bitstream_encoder dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_opcode     (req_opcode),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_valid_bits (rsp_valid_bits),
      .rsp_last       (rsp_last)
   );

   always #5 clock = ~clock;

   // Append one bit to the partial byte; a full byte goes to the item's list.
   function automatic void append_bit(logic b);
      pend_byte[pend_fill] = b;
      if (pend_fill == 7) begin
         item_bytes.push_back('{pend_byte, FULL_BYTE_BITS, 1'b0});
         pend_byte = '0;
         pend_fill = 0;
      end else begin
         pend_fill++;
      end
   endfunction

   // Groups low first, each followed by a continuation bit; zero is one all-zero group.
   function automatic void append_groups(logic [63:0] v, int first_size);
      int size;
      size = first_size;
      do begin
         for (int i = 0; i < size; i++)
            append_bit(v[i]);
         v = v >> size;
         append_bit(v != '0);
         size = GROUP_BITS;
      end while (v != '0);
   endfunction

   // Work out the bytes that one accepted item releases and queue them.
   function automatic void encode_item(logic [2:0] op, logic [63:0] v);
      item_bytes.delete();
      case (op)
         OP_UVAR: append_groups(v, GROUP_BITS);
         OP_SVAR: begin
            // The sign bit is 1 for a value that is not negative.
            if (v[63]) begin
               append_bit(1'b0);
               append_groups(~v + 64'd1, FIRST_SIGNED_BITS);
            end else begin
               append_bit(1'b1);
               append_groups(v, FIRST_SIGNED_BITS);
            end
         end
         OP_BIT: append_bit(v[0]);
         OP_BYTE: begin
            for (int i = 0; i < int'(FULL_BYTE_BITS); i++)
               append_bit(v[i]);
         end
         OP_FLUSH: begin
            // An empty partial byte flushes to nothing.
            if (pend_fill != 0) begin
               item_bytes.push_back('{pend_byte, 4'(pend_fill), 1'b0});
               pend_byte = '0;
               pend_fill = 0;
            end
         end
         default: ;
      endcase
      if (item_bytes.size() != 0)
         item_bytes[item_bytes.size() - 1].last = 1'b1;
      foreach (item_bytes[i])
         expected_bytes.push_back(item_bytes[i]);
   endfunction

   task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      $display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   // Offer one item after a random gap, or none when gapless, and hold it until the transfer.
   task automatic send_item(logic [2:0] op, logic [63:0] v);
      int gap;
      gap = tx_gapless ? 0 : $urandom_range(0, MAX_WAIT);
      @(negedge clock);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_opcode <= op;
      req_value  <= v;
      req_valid  <= 1'b1;
      do @(posedge clock); while (!req_ready);
      encode_item(op, v);
   endtask

   // Stop offering, then wait until every predicted byte has come out.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0)
         @(posedge clock);
   endtask

   function automatic logic [63:0] rand_word();
      return {$urandom, $urandom};
   endfunction

   // Random value of random bit length, so that every group count shows up.
   function automatic logic [63:0] rand_sized();
      int len;
      logic [63:0] w;
      len = $urandom_range(0, 64);
      w = rand_word();
      return (len == 64) ? w : (w & ((64'd1 << len) - 64'd1));
   endfunction

   // One random item, mostly varints; spare opcodes do not count as items.
   task automatic send_random_item(output bit counted);
      int          pick;
      logic [63:0] v;
      pick = $urandom_range(0, 99);
      counted = 1'b1;
      if (pick < 35) begin
         send_item(OP_UVAR, rand_sized());
      end else if (pick < 65) begin
         v = rand_sized();
         if ($urandom_range(0, 1) != 0)
            v = ~v + 64'd1;
         send_item(OP_SVAR, v);
      end else if (pick < 80) begin
         send_item(OP_BIT, rand_word());
      end else if (pick < 92) begin
         send_item(OP_BYTE, rand_word());
      end else if (pick < 98) begin
         send_item(OP_FLUSH, rand_word());
      end else begin
         send_item(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), rand_word());
         counted = 1'b0;
      end
   endtask

   task automatic run_random_items(int count);
      int sent;
      bit counted;
      sent = 0;
      while (sent < count) begin
         send_random_item(counted);
         if (counted)
            sent++;
      end
   endtask

   // Field extremes, every opcode, empty and partial flushes, spare opcodes.
   task automatic test_directed();
      send_item(OP_UVAR, 64'd0);
      send_item(OP_UVAR, 64'd1);
      send_item(OP_UVAR, 64'd127);
      send_item(OP_UVAR, 64'd128);
      send_item(OP_UVAR, '1);
      send_item(OP_UVAR, MOST_NEGATIVE);
      send_item(OP_SVAR, 64'd0);
      send_item(OP_SVAR, 64'd1);
      send_item(OP_SVAR, 64'd63);
      send_item(OP_SVAR, 64'd64);
      send_item(OP_SVAR, '1);
      send_item(OP_SVAR, MOST_POSITIVE);
      send_item(OP_SVAR, MOST_NEGATIVE);
      send_item(OP_BIT, ~64'd1);
      send_item(OP_BIT, '1);
      send_item(OP_BYTE, 64'd0);
      send_item(OP_BYTE, '1);
      send_item(OP_BYTE, 64'hFFFF_FFFF_FFFF_FF00);
      send_item(OP_FLUSH, '1);
      send_item(OP_FLUSH, '0);
      send_item(OP_BIT, 64'd1);
      send_item(OP_FLUSH, '0);
      for (logic [3:0] op = {1'b0, OP_SPARE_FIRST}; op <= {1'b0, OP_SPARE_LAST}; op++)
         send_item(op[2:0], '1);
      wait_drained();
   endtask

   task automatic test_random_stream();
      run_random_items(40);
      wait_drained();
   endtask

   // The receiver holds off while long varints keep coming, so the input stalls.
   task automatic test_receiver_hold();
      hold_len = HOLD_CYCLES;
      tx_gapless = 1'b1;
      repeat (12) send_item(OP_UVAR, '1);
      send_item(OP_SVAR, MOST_NEGATIVE);
      tx_gapless = 1'b0;
      wait_drained();
   endtask

   // Back-to-back transfers on both sides.
   task automatic test_gapless();
      tx_gapless = 1'b1;
      rx_gapless = 1'b1;
      run_random_items(30);
      tx_gapless = 1'b0;
      rx_gapless = 1'b0;
      wait_drained();
   endtask

   // Receiver: a long hold when asked, else a random stall before each transfer unless gapless.
   initial begin : receiver
      int stall;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_len != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_len) @(negedge clock);
            hold_len = 0;
         end
         stall = rx_gapless ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Compare each output transfer with the oldest prediction; watch for a hang.
   always @(posedge clock) begin : result_check
      coded_byte_type head;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_bytes.size() == 0) begin
               report_mismatch("byte with nothing expected", 64'(rsp_out_byte), '0);
            end else begin
               head = expected_bytes.pop_front();
               if (rsp_out_byte !== head.data)
                  report_mismatch("out_byte", 64'(rsp_out_byte), 64'(head.data));
               if (rsp_valid_bits !== head.nbits)
                  report_mismatch("valid_bits", 64'(rsp_valid_bits), 64'(head.nbits));
               if (rsp_last !== head.last)
                  report_mismatch("last", 64'(rsp_last), 64'(head.last));
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random_stream();
      test_receiver_hold();
      test_gapless();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_bytes.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
